// ----- rtl/assert_macros.svh -----
// Assertion helpers for the lexer RTL; the enclosing module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge outside reset.
`define CHSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a property in the next.
`define CHSL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);

`endif

// ----- rtl/chsl_pkg.sv -----
// ----------------------------------------------------------------------------
// chsl_pkg
// Shared types, class codes, colors and the keyword table of the C lexer.
// ----------------------------------------------------------------------------
package chsl_pkg;

  typedef logic [2:0] hl_class_t;
  typedef logic [3:0] run_t;    // run length of one mark, keywords are at most 8 long
  typedef logic [1:0] quote_t;
  typedef logic [1:0] reg_idx_t;

  localparam hl_class_t CL_NORMAL  = 3'd0;
  localparam hl_class_t CL_COMMENT = 3'd1;
  localparam hl_class_t CL_BLOCK   = 3'd2;
  localparam hl_class_t CL_KW1     = 3'd3;
  localparam hl_class_t CL_KW2     = 3'd4;
  localparam hl_class_t CL_STRING  = 3'd5;
  localparam hl_class_t CL_NUMBER  = 3'd6;

  localparam logic [5:0] COLOR_COMMENT = 6'd36;
  localparam logic [5:0] COLOR_KW1     = 6'd33;
  localparam logic [5:0] COLOR_KW2     = 6'd32;
  localparam logic [5:0] COLOR_STRING  = 6'd35;
  localparam logic [5:0] COLOR_NUMBER  = 6'd31;
  localparam logic [5:0] COLOR_NORMAL  = 6'd37;

  localparam quote_t SQ_NONE   = 2'd0;
  localparam quote_t SQ_DOUBLE = 2'd1;
  localparam quote_t SQ_SINGLE = 2'd2;

  localparam reg_idx_t REG_SYNTAX_ENABLE = 2'd0;
  localparam reg_idx_t REG_HL_STRINGS    = 2'd1;
  localparam reg_idx_t REG_HL_NUMBERS    = 2'd2;

  // Head entries the classifier looks at: longest keyword plus its separator.
  localparam int PEEK_N   = 9;
  localparam int KW_MAX   = 8;
  localparam int KW_COUNT = 23;

  localparam logic [63:0] KW_WORD [KW_COUNT] = '{
    64'("switch"), 64'("if"), 64'("while"), 64'("for"), 64'("break"),
    64'("continue"), 64'("return"), 64'("else"), 64'("struct"), 64'("union"),
    64'("typedef"), 64'("static"), 64'("enum"), 64'("class"), 64'("case"),
    64'("int"), 64'("long"), 64'("double"), 64'("float"), 64'("char"),
    64'("unsigned"), 64'("signed"), 64'("void")
  };
  localparam run_t KW_LEN [KW_COUNT] = '{
    4'd6, 4'd2, 4'd5, 4'd3, 4'd5, 4'd8, 4'd6, 4'd4, 4'd6, 4'd5, 4'd7, 4'd6,
    4'd4, 4'd5, 4'd4, 4'd3, 4'd4, 4'd6, 4'd5, 4'd4, 4'd8, 4'd6, 4'd4
  };
  localparam hl_class_t KW_CLS [KW_COUNT] = '{
    CL_KW1, CL_KW1, CL_KW1, CL_KW1, CL_KW1, CL_KW1, CL_KW1, CL_KW1, CL_KW1,
    CL_KW1, CL_KW1, CL_KW1, CL_KW1, CL_KW1, CL_KW1,
    CL_KW2, CL_KW2, CL_KW2, CL_KW2, CL_KW2, CL_KW2, CL_KW2, CL_KW2
  };

  // Per-row lexer state plus the open block comment flag.
  typedef struct packed {
    logic      in_block;
    quote_t    quote;
    logic      after_sep;
    hl_class_t prev_class;
  } lex_state_t;

  // One classification: class and how many head characters it covers.
  typedef struct packed {
    hl_class_t cls;
    run_t      len;
  } mark_t;

  function automatic logic is_sep(logic [7:0] c);
    return (c == 8'h00) || (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D)) ||
           (c == 8'h2C) || (c == 8'h2E) || (c == 8'h28) || (c == 8'h29) ||
           (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2F) || (c == 8'h2A) ||
           (c == 8'h3D) || (c == 8'h7E) || (c == 8'h25) || (c == 8'h3C) ||
           (c == 8'h3E) || (c == 8'h5B) || (c == 8'h5D) || (c == 8'h3B);
  endfunction

  function automatic logic [5:0] color_of(hl_class_t cls);
    logic [5:0] col;
    case (cls)
      CL_COMMENT, CL_BLOCK: col = COLOR_COMMENT;
      CL_KW1:               col = COLOR_KW1;
      CL_KW2:               col = COLOR_KW2;
      CL_STRING:            col = COLOR_STRING;
      CL_NUMBER:            col = COLOR_NUMBER;
      default:              col = COLOR_NORMAL;
    endcase
    return col;
  endfunction

endpackage

// ----- rtl/c_syntax_highlight_lexer_unit.sv -----
// ----------------------------------------------------------------------------
// c_syntax_highlight_lexer_unit
// Streaming C syntax highlighter, one character item in, one class item out.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_stall): one character of a row with its
// row_start, last_in_row and carry_comment marks. Output channel
// (res_valid/res_stall): one item per character, oldest first, with class,
// ANSI color, row_end, open_comment_out and last_of_run.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 syntax_enable,
// 1 highlight_strings, 2 highlight_numbers; write only while idle.
// Characters wait in a LOOKAHEAD-entry window until it is full or the row ends;
// then the head is classified and its run (1..8 characters) drains one result
// per cycle unless the output stalls. Throughput is one character per cycle
// when input is not held off, set by the window's single shift/append port. A
// character's result leaves LOOKAHEAD-1 characters later, or in the row-end
// flush, via the output register. The flush emits one result per cycle unless
// the output stalls; input is held off until it ends. A row_start item waits
// until a running mark has drained. Reset (rst, synchronous): window empty,
// state cleared, syntax disabled, strings and numbers enabled. A stall on the
// output freezes the engine and fills the window, after which item_stall rises.
module c_syntax_highlight_lexer_unit #(
  parameter int LOOKAHEAD = 9
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] ch,
  input  logic       row_start,
  input  logic       last_in_row,
  input  logic       carry_comment,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] hl_class,
  output logic [5:0] color,
  output logic       row_end,
  output logic       open_comment_out,
  output logic       last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);

`include "assert_macros.svh"

  localparam int CW = $clog2(LOOKAHEAD + 1);

  // configuration
  logic syntax_enable;
  logic hl_strings;
  logic hl_numbers;

  // engine state
  logic [CW-1:0]        pending;
  logic [7:0]           peek [chsl_pkg::PEEK_N];
  chsl_pkg::run_t       run_left;
  chsl_pkg::hl_class_t  run_cls;
  logic                 run_flush;   // current run belongs to a row-end flush
  logic                 flushing;
  chsl_pkg::lex_state_t st;

  chsl_pkg::mark_t      mk;
  chsl_pkg::lex_state_t st_cls;
  chsl_pkg::lex_state_t st_eff;

  logic                 due;
  logic                 out_free;
  logic                 adv;
  logic                 classify;
  logic                 accept;
  logic                 final_flush;
  logic                 rf;
  chsl_pkg::run_t       k_eff;
  chsl_pkg::run_t       run_after;
  chsl_pkg::hl_class_t  emit_cls;
  chsl_pkg::hl_class_t  shown;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      syntax_enable <= 1'b0;
      hl_strings    <= 1'b1;
      hl_numbers    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        chsl_pkg::REG_SYNTAX_ENABLE: syntax_enable <= cfg_data;
        chsl_pkg::REG_HL_STRINGS:    hl_strings    <= cfg_data;
        chsl_pkg::REG_HL_NUMBERS:    hl_numbers    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Head classification is due when the window is full or a flush is running,
  // and no earlier mark is still draining.
  assign due      = (run_left == '0) &&
                    ((pending == CW'(LOOKAHEAD)) || (flushing && (pending != '0)));
  assign out_free = !res_valid || !res_stall;
  assign adv      = ((run_left != '0) || due) && out_free;
  assign classify = due && out_free;

  assign item_stall = flushing || ((pending == CW'(LOOKAHEAD)) && !adv) ||
                      (row_start && ((run_left != '0) || (pending == CW'(LOOKAHEAD))));
  assign accept     = item_valid && !item_stall;

  chsl_window #(
    .LOOKAHEAD(LOOKAHEAD)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .shift   (adv),
    .push    (accept),
    .clear   (accept && row_start),
    .din     (ch),
    .pending (pending),
    .peek    (peek)
  );

  chsl_classify u_classify (
    .peek          (peek),
    .more_than_one (pending > CW'(1)),
    .hl_strings    (hl_strings),
    .hl_numbers    (hl_numbers),
    .st            (st),
    .mk            (mk),
    .st_next       (st_cls)
  );

  // A mark never covers more characters than are waiting.
  always_comb begin
    if (CW'(mk.len) > pending) begin
      k_eff = chsl_pkg::run_t'(pending);
    end else begin
      k_eff = mk.len;
    end
    emit_cls    = classify ? mk.cls : run_cls;
    run_after   = classify ? (k_eff - 4'd1) : (run_left - 4'd1);
    rf          = classify ? flushing : run_flush;
    final_flush = flushing && (pending == CW'(1));
    st_eff      = classify ? st_cls : st;
    shown       = syntax_enable ? emit_cls : chsl_pkg::CL_NORMAL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_left  <= '0;
      run_cls   <= chsl_pkg::CL_NORMAL;
      run_flush <= 1'b0;
      flushing  <= 1'b0;
      st        <= '{in_block: 1'b0, quote: chsl_pkg::SQ_NONE, after_sep: 1'b1,
                     prev_class: chsl_pkg::CL_NORMAL};
    end else begin
      if (adv) begin
        run_left <= run_after;
        if (classify) begin
          run_cls   <= mk.cls;
          run_flush <= flushing;
        end
        // row end: row state restarts, open comment carries on
        if (final_flush) begin
          flushing <= 1'b0;
          st       <= '{in_block: st_eff.in_block, quote: chsl_pkg::SQ_NONE,
                        after_sep: 1'b1, prev_class: chsl_pkg::CL_NORMAL};
        end else if (classify) begin
          st <= st_cls;
        end
      end
      if (accept) begin
        if (row_start) begin
          st <= '{in_block: carry_comment, quote: chsl_pkg::SQ_NONE, after_sep: 1'b1,
                  prev_class: chsl_pkg::CL_NORMAL};
        end
        if (last_in_row) begin
          flushing <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= adv;
    end
    if (adv) begin
      hl_class         <= shown;
      color            <= chsl_pkg::color_of(shown);
      row_end          <= final_flush;
      open_comment_out <= final_flush && syntax_enable && st_eff.in_block;
      last_of_run      <= final_flush || (!rf && (run_after == '0));
    end
  end

  `CHSL_ASSERT(a_pending_max, (pending <= CW'(LOOKAHEAD)), "window overfilled")
  `CHSL_ASSERT(a_run_fits, (CW'(run_left) <= pending), "run longer than window")
  `CHSL_ASSERT(a_row_end_last, (res_valid && row_end |-> last_of_run), "row end not last")
  `CHSL_ASSERT(a_flush_stalls, (flushing |-> item_stall), "item taken during flush")
  `CHSL_ASSERT_NEXT(a_flush_starts, (accept && last_in_row), flushing, "flush did not start")

endmodule

// ----- rtl/chsl_window.sv -----
// ----------------------------------------------------------------------------
// chsl_window
// Lookahead window: drops the head by one, appends at the tail, clears on row start.
// ----------------------------------------------------------------------------
module chsl_window #(
  parameter int LOOKAHEAD = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift,
  input  logic                           push,
  input  logic                           clear,
  input  logic [7:0]                     din,
  output logic [$clog2(LOOKAHEAD+1)-1:0] pending,
  output logic [7:0]                     peek [chsl_pkg::PEEK_N]
);

  localparam int CW = $clog2(LOOKAHEAD + 1);

  logic [7:0]    win      [LOOKAHEAD];
  logic [7:0]    win_next [LOOKAHEAD];
  logic [CW-1:0] pending_next;
  logic [CW-1:0] base;

  always_comb begin
    base = clear ? '0 : (pending - CW'(shift));
    for (int i = 0; i < LOOKAHEAD; i++) begin
      if (shift && (i + 1 < LOOKAHEAD)) begin
        win_next[i] = win[(i + 1) % LOOKAHEAD];
      end else begin
        win_next[i] = win[i];
      end
      if (push && (base == CW'(i))) begin
        win_next[i] = din;
      end
    end
    pending_next = base + CW'(push);
  end

  always_comb begin
    for (int j = 0; j < chsl_pkg::PEEK_N; j++) begin
      peek[j] = (CW'(j) < pending) ? win[j] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

endmodule

// ----- rtl/chsl_classify.sv -----
// ----------------------------------------------------------------------------
// chsl_classify
// Classifies the window head: comments, strings, numbers, whole-word keywords.
// ----------------------------------------------------------------------------
module chsl_classify (
  input  logic                   [7:0] peek [chsl_pkg::PEEK_N],
  input  logic                         more_than_one,
  input  logic                         hl_strings,
  input  logic                         hl_numbers,
  input  chsl_pkg::lex_state_t         st,
  output chsl_pkg::mark_t              mk,
  output chsl_pkg::lex_state_t         st_next
);

  logic                kw_hit;
  chsl_pkg::mark_t     kw_mark;
  logic                match;
  logic [7:0]          c0;
  logic [7:0]          c1;
  logic                digit;

  // Keyword search, first table entry wins.
  always_comb begin
    kw_hit  = 1'b0;
    kw_mark = '0;
    for (int n = chsl_pkg::KW_COUNT - 1; n >= 0; n--) begin
      match = 1'b1;
      for (int j = 0; j < chsl_pkg::KW_MAX; j++) begin
        if ((j < int'(chsl_pkg::KW_LEN[n])) &&
            (peek[j] != chsl_pkg::KW_WORD[n][8*(int'(chsl_pkg::KW_LEN[n])-1-j) +: 8])) begin
          match = 1'b0;
        end
      end
      if (match && chsl_pkg::is_sep(peek[chsl_pkg::KW_LEN[n]])) begin
        kw_hit  = 1'b1;
        kw_mark = '{cls: chsl_pkg::KW_CLS[n], len: chsl_pkg::KW_LEN[n]};
      end
    end
  end

  always_comb begin
    c0      = peek[0];
    c1      = peek[1];
    digit   = (c0 >= 8'h30) && (c0 <= 8'h39);
    st_next = st;
    mk      = '{cls: chsl_pkg::CL_NORMAL, len: 4'd1};
    if (st.prev_class == chsl_pkg::CL_COMMENT) begin
      mk.cls = chsl_pkg::CL_COMMENT;
    end else if ((st.quote == chsl_pkg::SQ_NONE) && !st.in_block &&
                 (c0 == 8'h2F) && (c1 == 8'h2F)) begin
      mk.cls = chsl_pkg::CL_COMMENT;
    end else if ((st.quote == chsl_pkg::SQ_NONE) && st.in_block) begin
      mk.cls = chsl_pkg::CL_BLOCK;
      if ((c0 == 8'h2A) && (c1 == 8'h2F)) begin
        mk.len            = 4'd2;
        st_next.in_block  = 1'b0;
        st_next.after_sep = 1'b1;
      end
    end else if ((st.quote == chsl_pkg::SQ_NONE) && (c0 == 8'h2F) && (c1 == 8'h2A)) begin
      mk               = '{cls: chsl_pkg::CL_BLOCK, len: 4'd2};
      st_next.in_block = 1'b1;
    end else if (hl_strings && (st.quote != chsl_pkg::SQ_NONE)) begin
      mk.cls = chsl_pkg::CL_STRING;
      if ((c0 == 8'h5C) && more_than_one) begin
        mk.len = 4'd2;
      end else begin
        if (((st.quote == chsl_pkg::SQ_DOUBLE) && (c0 == 8'h22)) ||
            ((st.quote == chsl_pkg::SQ_SINGLE) && (c0 == 8'h27))) begin
          st_next.quote = chsl_pkg::SQ_NONE;
        end
        st_next.after_sep = 1'b1;
      end
    end else if (hl_strings && ((c0 == 8'h22) || (c0 == 8'h27))) begin
      mk.cls        = chsl_pkg::CL_STRING;
      st_next.quote = (c0 == 8'h22) ? chsl_pkg::SQ_DOUBLE : chsl_pkg::SQ_SINGLE;
    end else if (hl_numbers &&
                 ((digit && (st.after_sep || (st.prev_class == chsl_pkg::CL_NUMBER))) ||
                  ((c0 == 8'h2E) && (st.prev_class == chsl_pkg::CL_NUMBER)))) begin
      mk.cls            = chsl_pkg::CL_NUMBER;
      st_next.after_sep = 1'b0;
    end else if (st.after_sep && kw_hit) begin
      mk                = kw_mark;
      st_next.after_sep = 1'b0;
    end else begin
      st_next.after_sep = chsl_pkg::is_sep(c0);
    end
    st_next.prev_class = mk.cls;
  end

endmodule
